// ===== design/tcce_pkg.sv =====
`timescale 1ns / 1ps
// Package for the text console character engine.
// Holds field widths, character and item codes, and the cursor step control struct.
// Depends on nothing.
package tcce_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int ARG_W  = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int POS_W  = 11;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR  = 2'd0,
      KIND_SET   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Control outcome of one character item.
   typedef struct packed {
      logic wr_en;   // a cell on the cursor row is written
      logic scroll;  // the cursor ran past the last row
   } step_type;

endpackage

// ===== design/tcce_cursor_step.sv =====
`timescale 1ns / 1ps
// Cursor step logic for one character item: control codes, wrap and scroll detection.
// Depends on tcce_pkg.
module tcce_cursor_step #(
   parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
   input  logic [$clog2(COLUMNS)-1:0]  cur_col,
   input  logic [$clog2(ROWS)-1:0]     cur_row,
   input  logic [tcce_pkg::CHAR_W-1:0] ch,
   output logic [$clog2(COLUMNS)-1:0]  next_col,
   output logic [$clog2(ROWS)-1:0]     next_row,
   output logic [$clog2(COLUMNS)-1:0]  wr_col,
   output logic [tcce_pkg::CHAR_W-1:0] wr_char,
   output tcce_pkg::step_type          ctl
);
   import tcce_pkg::*;

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);

   logic [COL_W:0] col_wide;
   logic [COL_W:0] col_new;
   logic           row_adv;

   always_comb begin
      col_wide = {1'b0, cur_col};
      col_new  = col_wide;
      row_adv  = 1'b0;
      wr_col   = cur_col;
      wr_char  = ch;
      ctl      = '0;

      unique case (ch)
         CH_LF: begin
            col_new = '0;
            row_adv = 1'b1;
         end
         CH_CR: begin
            col_new = '0;
         end
         CH_TAB: begin
            col_new = (col_wide + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
         end
         CH_BS: begin
            if (cur_col != '0) begin
               col_new   = col_wide - (COL_W+1)'(1);
               wr_col    = cur_col - COL_W'(1);
               wr_char   = CH_SPACE;
               ctl.wr_en = 1'b1;
            end
         end
         default: begin
            col_new   = col_wide + (COL_W+1)'(1);
            ctl.wr_en = 1'b1;
         end
      endcase

      // Running off the right edge wraps to the start of the next row.
      if (col_new >= (COL_W+1)'(COLUMNS)) begin
         col_new = '0;
         row_adv = 1'b1;
      end

      next_col = col_new[COL_W-1:0];
      next_row = cur_row;
      if (row_adv) begin
         if (cur_row == ROW_W'(ROWS - 1)) begin
            ctl.scroll = 1'b1;
         end else begin
            next_row = cur_row + ROW_W'(1);
         end
      end
   end

endmodule

// ===== design/text_console_character_engine.sv =====
`timescale 1ns / 1ps
// Text console character engine: screen store, cursor and item sequencer.
// Depends on tcce_pkg and tcce_cursor_step.
//
// Usage:
// An item (kind, ch, col_arg, row_arg) is taken at a rising edge where start is
// high and busy is low. Its single result transaction (cursor_pos, cell_value)
// appears on the rsp_ ports, marked by rsp_valid, in the cycle right after the
// item is taken. The receiver cannot hold results off; each one is shown for
// exactly one cycle.
// Character, set-cursor and read items leave busy low, so a new item can be taken
// in every cycle except while a scroll blanks its row. The screen store is a
// single-port-write, single-port-read memory with a registered read; its one write
// port sets the cost of the long items. A scroll blanks the recycled bottom row at
// one cell a cycle, which keeps busy high until the whole row is written. A clear
// writes every cell (2000 at the default size), keeping busy high until its sweep
// ends. Reset is synchronous and active high. After reset the block runs the same
// sweep over the whole store to fill it with blank cells in attribute 0x0F, keeping
// busy high until that sweep ends. The attribute register is written through the
// csr_ channel at any time it is ready, but is only meant to change while the block
// is idle.
// Scrolling does not move data: the store is a ring of rows, and a row base
// register maps screen rows to physical rows.
module text_console_character_engine #(
   parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   // Item channel.
   input  logic                        start,
   output logic                        busy,
   input  logic [tcce_pkg::KIND_W-1:0] req_kind,
   input  logic [tcce_pkg::CHAR_W-1:0] req_ch,
   input  logic [tcce_pkg::ARG_W-1:0]  req_col_arg,
   input  logic [tcce_pkg::ARG_W-1:0]  req_row_arg,
   // Result channel.
   output logic                        rsp_valid,
   output logic [tcce_pkg::POS_W-1:0]  rsp_cursor_pos,
   output logic [tcce_pkg::CELL_W-1:0] rsp_cell_value,
   // Attribute register write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tcce_pkg::ATTR_W-1:0] csr_attribute
);
   import tcce_pkg::*;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_COL_A = ADDR_W'(COLUMNS - 1);

   // One-hot sequencer states: idle, or sweeping blank cells into the store.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   // Screen row to physical row through the ring base.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] base);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, base};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(prow * COLS_A) + ADDR_W'(col);
   endfunction

   state_type               state_ff, state_in;
   logic [COL_W-1:0]        cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]        cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]        base_ff, base_in;
   logic [ATTR_W-1:0]       attr_ff, attr_in;
   logic [ADDR_W-1:0]       fill_addr_ff, fill_addr_in;
   logic [ADDR_W-1:0]       fill_left_ff, fill_left_in;
   logic [CELL_W-1:0]       fill_word_ff, fill_word_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_rd_ff, rsp_rd_in;
   logic [CELL_W-1:0]       mem_q_ff;

   logic [CELL_W-1:0]       screen_mem [CELLS];
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [CELL_W-1:0]       mem_wdata;
   logic                    mem_re;
   logic [ADDR_W-1:0]       mem_raddr;

   logic                    accept;
   logic                    arg_in_range;
   logic [COL_W-1:0]        step_next_col;
   logic [ROW_W-1:0]        step_next_row;
   logic [COL_W-1:0]        step_wr_col;
   logic [CHAR_W-1:0]       step_wr_char;
   step_type                step_ctl;
   logic [ROW_W-1:0]        base_next;
   logic [ADDR_W-1:0]       pos_full;

   tcce_cursor_step #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_step (
      .cur_col  (cur_col_ff),
      .cur_row  (cur_row_ff),
      .ch       (req_ch),
      .next_col (step_next_col),
      .next_row (step_next_row),
      .wr_col   (step_wr_col),
      .wr_char  (step_wr_char),
      .ctl      (step_ctl)
   );

   // Handshake status. Nothing is taken while reset is asserted.
   assign busy      = (state_ff != ST_IDLE) || reset;
   assign accept    = start && !busy;
   assign csr_ready = !reset;

   assign arg_in_range = ({1'b0, req_col_arg} < (ARG_W+1)'(COLUMNS)) &&
                         ({1'b0, req_row_arg} < (ARG_W+1)'(ROWS));

   // The ring advances by one row on a scroll; the old top row becomes the bottom.
   assign base_next = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + ROW_W'(1);

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      base_in      = base_ff;
      attr_in      = attr_ff;
      fill_addr_in = fill_addr_ff;
      fill_left_in = fill_left_ff;
      fill_word_in = fill_word_ff;
      rsp_valid_in = accept;
      rsp_rd_in    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cell_addr(phys_row(cur_row_ff, base_ff), step_wr_col);
      mem_wdata    = {attr_ff, step_wr_char};
      mem_re       = 1'b0;
      mem_raddr    = cell_addr(phys_row(req_row_arg[ROW_W-1:0], base_ff),
                               req_col_arg[COL_W-1:0]);

      if (csr_valid && csr_ready) begin
         attr_in = csr_attribute;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_CHAR: begin
                     mem_we     = step_ctl.wr_en;
                     cur_col_in = step_next_col;
                     cur_row_in = step_next_row;
                     if (step_ctl.scroll) begin
                        // Blank the physical row that is now the bottom screen row.
                        base_in      = base_next;
                        fill_addr_in = cell_addr(base_ff, '0);
                        fill_left_in = LAST_COL_A;
                        fill_word_in = {attr_ff, CH_SPACE};
                        state_in     = ST_FILL;
                     end
                  end
                  KIND_SET: begin
                     if (arg_in_range) begin
                        cur_col_in = req_col_arg[COL_W-1:0];
                        cur_row_in = req_row_arg[ROW_W-1:0];
                     end
                  end
                  KIND_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     base_in      = '0;
                     fill_addr_in = '0;
                     fill_left_in = LAST_CELL;
                     fill_word_in = {attr_ff, CH_SPACE};
                     state_in     = ST_FILL;
                  end
                  KIND_READ: begin
                     mem_re    = arg_in_range;
                     rsp_rd_in = arg_in_range;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            mem_waddr    = fill_addr_ff;
            mem_wdata    = fill_word_ff;
            fill_addr_in = fill_addr_ff + ADDR_W'(1);
            fill_left_in = fill_left_ff - ADDR_W'(1);
            if (fill_left_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Reset starts a full pass that fills the store with default blanks.
         state_ff     <= ST_FILL;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         base_ff      <= '0;
         attr_ff      <= RESET_ATTR;
         fill_addr_ff <= '0;
         fill_left_ff <= LAST_CELL;
         fill_word_ff <= {RESET_ATTR, CH_SPACE};
         rsp_valid_ff <= 1'b0;
         rsp_rd_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         base_ff      <= base_in;
         attr_ff      <= attr_in;
         fill_addr_ff <= fill_addr_in;
         fill_left_ff <= fill_left_in;
         fill_word_ff <= fill_word_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_rd_ff    <= rsp_rd_in;
      end
   end

   // Screen store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= screen_mem[mem_raddr];
      end
   end

   // The cursor registers already hold the post-item position in the result cycle.
   assign pos_full       = ADDR_W'(cur_row_ff * COLS_A) + ADDR_W'(cur_col_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = POS_W'(pos_full);
   assign rsp_cell_value = rsp_rd_ff ? mem_q_ff : '0;

endmodule

// ===== design/tcce_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the text console character engine, bound to the top level.
// Depends on tcce_pkg and text_console_character_engine.
module tcce_checker #(
   parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [tcce_pkg::KIND_W-1:0] req_kind,
   input logic                        rsp_valid,
   input logic [tcce_pkg::POS_W-1:0]  rsp_cursor_pos,
   input logic [tcce_pkg::CELL_W-1:0] rsp_cell_value
);
   import tcce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   // Every taken item yields its result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("item taken without a result in the next cycle");

   // No result appears without an item taken in the cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start) && !$past(busy))
      else $error("result without a taken item");

   // Only read items carry a cell value.
   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(req_kind) != KIND_READ) |-> rsp_cell_value == '0)
      else $error("nonzero cell value on a non-read result");

   // A clear homes the cursor and then sweeps the store.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KIND_CLEAR) |=> busy && (rsp_cursor_pos == '0))
      else $error("clear did not home the cursor or start its sweep");

   // The cursor never leaves the screen.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_pos < CELLS)
      else $error("cursor position off the screen");

endmodule

bind text_console_character_engine tcce_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcce_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_cell_value (rsp_cell_value)
);

// ===== tb/tcce_screen_tracker.sv =====
`timescale 1ns / 1ps
// Screen tracker for the text console character engine testbench.
// Mirrors the screen store, cursor and attribute, and checks every result transaction.
// Depends on tcce_pkg.
module tcce_screen_tracker #(
   parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [tcce_pkg::KIND_W-1:0] req_kind,
   input  logic [tcce_pkg::CHAR_W-1:0] req_ch,
   input  logic [tcce_pkg::ARG_W-1:0]  req_col_arg,
   input  logic [tcce_pkg::ARG_W-1:0]  req_row_arg,
   input  logic                        rsp_valid,
   input  logic [tcce_pkg::POS_W-1:0]  rsp_cursor_pos,
   input  logic [tcce_pkg::CELL_W-1:0] rsp_cell_value,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [tcce_pkg::ATTR_W-1:0] csr_attribute,
   output int                          fail_count,
   output int                          outstanding
);
   import tcce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_value;
   } console_report_type;

   logic [CELL_W-1:0]  screen_copy [CELLS];
   logic [ATTR_W-1:0]  attribute_copy;
   int                 cursor_row;
   int                 cursor_col;
   int                 mismatches;
   console_report_type awaited_reports[$];

   initial begin
      mismatches = 0;
   end

   task automatic scroll_screen();
      for (int i = 0; i < CELLS - COLUMNS; i++)
         screen_copy[i] = screen_copy[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++)
         screen_copy[i] = {attribute_copy, CH_SPACE};
      cursor_row = ROWS - 1;
   endtask

   task automatic type_character(input logic [CHAR_W-1:0] code);
      case (code)
         CH_LF: begin
            cursor_col = 0;
            cursor_row++;
         end
         CH_CR: cursor_col = 0;
         CH_TAB: cursor_col = (cursor_col + 4) & ~3;
         CH_BS: begin
            if (cursor_col > 0) begin
               cursor_col--;
               screen_copy[cursor_row * COLUMNS + cursor_col] = {attribute_copy, CH_SPACE};
            end
         end
         default: begin
            screen_copy[cursor_row * COLUMNS + cursor_col] = {attribute_copy, code};
            cursor_col++;
         end
      endcase
      if (cursor_col >= COLUMNS) begin
         cursor_col = 0;
         cursor_row++;
      end
      if (cursor_row >= ROWS)
         scroll_screen();
   endtask

   // Applies one item to the mirrored console and returns the report it should produce.
   task automatic apply_item(input kind_type kind, input logic [CHAR_W-1:0] code,
                             input int col, input int row,
                             output console_report_type report);
      logic [CELL_W-1:0] read_value;
      read_value = '0;
      case (kind)
         KIND_CHAR: type_character(code);
         KIND_SET: begin
            if (col < COLUMNS && row < ROWS) begin
               cursor_col = col;
               cursor_row = row;
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_copy[i] = {attribute_copy, CH_SPACE};
            cursor_row = 0;
            cursor_col = 0;
         end
         default: begin
            if (col < COLUMNS && row < ROWS)
               read_value = screen_copy[row * COLUMNS + col];
         end
      endcase
      report.cursor_pos = POS_W'(cursor_row * COLUMNS + cursor_col);
      report.cell_value = read_value;
   endtask

   task automatic note_failure(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      console_report_type report;
      if (reset) begin
         attribute_copy = RESET_ATTR;
         cursor_row     = 0;
         cursor_col     = 0;
         for (int i = 0; i < CELLS; i++)
            screen_copy[i] = {RESET_ATTR, CH_SPACE};
         awaited_reports.delete();
      end else begin
         // A result always belongs to an item taken at an earlier edge, so it is checked
         // before the item of this edge is queued.
         if (rsp_valid) begin
            if (awaited_reports.size() == 0) begin
               note_failure($sformatf("result pos=%0d value=%h with no transaction waiting",
                                      rsp_cursor_pos, rsp_cell_value));
            end else begin
               report = awaited_reports.pop_front();
               if (rsp_cursor_pos !== report.cursor_pos || rsp_cell_value !== report.cell_value)
                  note_failure($sformatf("expected pos=%0d value=%h, got pos=%0d value=%h",
                                         report.cursor_pos, report.cell_value,
                                         rsp_cursor_pos, rsp_cell_value));
            end
         end
         if (csr_valid && csr_ready)
            attribute_copy = csr_attribute;
         if (start && !busy) begin
            apply_item(kind_type'(req_kind), req_ch, int'(req_col_arg), int'(req_row_arg),
                       report);
            awaited_reports.push_back(report);
         end
      end
      outstanding <= awaited_reports.size();
      fail_count  <= mismatches;
   end

endmodule

// ===== tb/text_console_character_engine_test.sv =====
`timescale 1ns / 1ps
// Top level of the text console character engine testbench: clock, reset and stimulus.
// Depends on tcce_pkg, text_console_character_engine and tcce_screen_tracker.
module text_console_character_engine_test;
   import tcce_pkg::*;

   localparam int COLUMNS = DEF_COLUMNS;
   localparam int ROWS    = DEF_ROWS;

   // Every input of the block starts from a known value.
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic [KIND_W-1:0]   req_kind      = KIND_CHAR;
   logic [CHAR_W-1:0]   req_ch        = '0;
   logic [ARG_W-1:0]    req_col_arg   = '0;
   logic [ARG_W-1:0]    req_row_arg   = '0;
   logic                csr_valid     = 1'b0;
   logic [ATTR_W-1:0]   csr_attribute = RESET_ATTR;

   logic                busy;
   logic                rsp_valid;
   logic [POS_W-1:0]    rsp_cursor_pos;
   logic [CELL_W-1:0]   rsp_cell_value;
   logic                csr_ready;

   int                  fail_count;
   int                  outstanding;
   // Chance in percent that the sender pauses after a transaction; set per phase.
   int                  idle_chance = 0;

   always #5 clock = ~clock;

   text_console_character_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_ch         (req_ch),
      .req_col_arg    (req_col_arg),
      .req_row_arg    (req_row_arg),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_attribute  (csr_attribute)
   );

   // The tracker watches all three channels, mirrors the console and counts failures.
   tcce_screen_tracker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) screen_tracker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_ch         (req_ch),
      .req_col_arg    (req_col_arg),
      .req_row_arg    (req_row_arg),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_attribute  (csr_attribute),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   // Presents one item and holds it until the block takes it. The sender may then go
   // quiet for a burst of cycles. When it does not, the next call raises start again in
   // the same step, so start simply stays high between back-to-back transactions.
   task automatic send_item(input kind_type kind, input logic [CHAR_W-1:0] code,
                            input logic [ARG_W-1:0] col, input logic [ARG_W-1:0] row);
      start       <= 1'b1;
      req_kind    <= kind;
      req_ch      <= code;
      req_col_arg <= col;
      req_row_arg <= row;
      do @(posedge clock); while (busy);
      if ($urandom_range(1, 100) <= idle_chance) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // The attribute only changes while the block is idle: no result outstanding and no
   // scroll, clear or start-up fill still walking the store.
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      csr_valid     <= 1'b1;
      csr_attribute <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random item. Most of them are characters, so text builds up, wraps and scrolls;
   // set-cursor items lean toward the bottom rows to reach scrolling often, and reads
   // sample the whole screen. Clears are rare because each one walks the whole store.
   task automatic send_random_item();
      int                pick;
      int                sub;
      kind_type          kind;
      logic [CHAR_W-1:0] code;
      logic [ARG_W-1:0]  col;
      logic [ARG_W-1:0]  row;
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      code = CHAR_W'($urandom_range(0, 255));
      col  = ARG_W'($urandom_range(0, 255));
      row  = ARG_W'($urandom_range(0, 255));
      if (pick < 56) begin
         kind = KIND_CHAR;
         if (sub < 6)
            code = CH_LF;
         else if (sub < 9)
            code = CH_CR;
         else if (sub < 12)
            code = CH_TAB;
         else if (sub < 18)
            code = CH_BS;
         else if (sub >= 28)
            code = CHAR_W'($urandom_range(8'h21, 8'h7E));
      end else if (pick < 67) begin
         kind = KIND_SET;
         if (sub < 40) begin
            col = ARG_W'($urandom_range(0, COLUMNS - 1));
            row = ARG_W'(ROWS - 1 - $urandom_range(0, 2));
         end else if (sub < 80) begin
            col = ARG_W'($urandom_range(0, COLUMNS - 1));
            row = ARG_W'($urandom_range(0, ROWS - 1));
         end
      end else if (pick < 68) begin
         kind = KIND_CLEAR;
      end else begin
         kind = KIND_READ;
         if (sub < 85) begin
            col = ARG_W'($urandom_range(0, COLUMNS - 1));
            row = ARG_W'($urandom_range(0, ROWS - 1));
         end
      end
      send_item(kind, code, col, row);
   endtask

   initial begin
      logic [ATTR_W-1:0] attribute_plan [6];
      attribute_plan = '{8'hFF, 8'h80, 8'h01, 8'h0F, 8'hA5, 8'h00};
      attribute_plan[2] = ATTR_W'($urandom_range(0, 255));
      attribute_plan[4] = ATTR_W'($urandom_range(0, 255));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The attribute is set to its low extreme so that written cells are
      // told apart from the blank cells left by the start-up fill.
      write_attribute(8'h00);
      send_item(KIND_READ, 8'h00, 8'd0, 8'd0);       // untouched cell after reset
      send_item(KIND_CHAR, 8'h41, 8'd0, 8'd0);
      send_item(KIND_CHAR, 8'hFF, 8'hFF, 8'hFF);     // highest code is printable
      send_item(KIND_CHAR, 8'h00, 8'd0, 8'd0);       // lowest code is printable too
      send_item(KIND_CHAR, CH_BS, 8'd0, 8'd0);       // backspace blanks the cell
      send_item(KIND_CHAR, CH_TAB, 8'd0, 8'd0);
      send_item(KIND_CHAR, CH_CR, 8'd0, 8'd0);
      send_item(KIND_CHAR, CH_LF, 8'd0, 8'd0);
      send_item(KIND_READ, 8'h00, 8'd1, 8'd0);
      send_item(KIND_SET, 8'h00, ARG_W'(COLUMNS - 1), ARG_W'(ROWS - 1));
      send_item(KIND_CHAR, 8'h5A, 8'd0, 8'd0);       // last cell: wraps and scrolls
      send_item(KIND_READ, 8'h00, ARG_W'(COLUMNS - 1), ARG_W'(ROWS - 2));
      send_item(KIND_SET, 8'h00, ARG_W'(COLUMNS), 8'd0);  // out-of-range set is ignored
      send_item(KIND_SET, 8'h00, 8'd0, ARG_W'(ROWS));
      send_item(KIND_SET, 8'h00, 8'hFF, 8'hFF);
      send_item(KIND_READ, 8'h00, ARG_W'(COLUMNS), 8'd0); // out-of-range reads give zero
      send_item(KIND_READ, 8'h00, 8'hFF, 8'hFF);
      send_item(KIND_SET, 8'h00, ARG_W'(COLUMNS - 2), 8'd10);
      send_item(KIND_CHAR, CH_TAB, 8'd0, 8'd0);      // tab past the last column wraps
      send_item(KIND_SET, 8'h00, 8'd0, ARG_W'(ROWS - 1));
      send_item(KIND_CHAR, CH_LF, 8'd0, 8'd0);       // newline on the last row scrolls
      send_item(KIND_CHAR, CH_BS, 8'd0, 8'd0);       // backspace at column 0 does nothing
      send_item(KIND_CLEAR, 8'h00, 8'd0, 8'd0);
      send_item(KIND_READ, 8'h00, ARG_W'(COLUMNS - 1), ARG_W'(ROWS - 1));
      send_item(KIND_READ, 8'h00, 8'd0, ARG_W'(ROWS));

      // Random part in six phases, each with its own attribute. Idling alternates between
      // light and heavy phases, and the last phase runs with no idling at all.
      for (int phase = 0; phase < 6; phase++) begin
         write_attribute(attribute_plan[phase]);
         idle_chance = (phase == 5) ? 0 : ((phase % 2 == 1) ? 40 : 10);
         repeat (190) send_random_item();
      end
      start <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("text_console_character_engine: match");
      else
         $display("text_console_character_engine: mismatch");
      $finish;
   end

   // Even if every transaction were a clear followed by the longest idle burst, a run
   // would still end well within this time limit.
   initial begin
      #100ms;
      $display("text_console_character_engine: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
design/tcce_pkg.sv
design/tcce_cursor_step.sv
design/text_console_character_engine.sv
design/tcce_checker.sv
tb/tcce_screen_tracker.sv
tb/text_console_character_engine_test.sv
